[hdl/rqs_pkg.sv]
// Shared widths, codes and the control word type of the ready queue scheduler.
package rqs_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int PRIO_LEVELS   = 64;
   localparam int ID_W          = 8;
   localparam int PRIO_W        = 6;
   localparam int OPCODE_W      = 2;
   localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W         = 5;
   localparam int SLICE_W       = 8;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 8;

   localparam logic [PRIO_W-1:0]  PRIO_MAX    = PRIO_W'(PRIO_LEVELS - 1);
   localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(4);
   localparam logic [SLICE_W-1:0] SLICE_MAX   = '1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_TICK    = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLICY_MODE  = 1'd0,
      CSR_SLICE_LENGTH = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic              enqueue;
      logic              dequeue;
      logic              priority_mode;
      logic [ID_W-1:0]   new_id;
      logic [PRIO_W-1:0] new_prio;
   } cell_ctrl_type;

endpackage

[hdl/rqs_channels.sv]
// Handshake channel interfaces for requests, responses and register writes.
interface rqs_req_if;
   logic                              valid;
   logic                              ready;
   logic [rqs_pkg::OPCODE_W-1:0]      opcode;
   logic [rqs_pkg::ID_W-1:0]          task_id;
   logic [rqs_pkg::PRIO_W-1:0]        task_priority;

   modport source (output valid, output opcode, output task_id, output task_priority,
                   input ready);
   modport sink (input valid, input opcode, input task_id, input task_priority,
                 output ready);
endinterface

interface rqs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rqs_pkg::ID_W-1:0]          chosen_id;
   logic                              run_idle;
   logic                              yield_request;
   logic                              overflow_error;
   logic [rqs_pkg::OCC_W-1:0]         occupancy;

   modport source (output valid, output chosen_id, output run_idle, output yield_request,
                   output overflow_error, output occupancy, input ready);
   modport sink (input valid, input chosen_id, input run_idle, input yield_request,
                 input overflow_error, input occupancy, output ready);
endinterface

interface rqs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rqs_pkg::CSR_INDEX_W-1:0]   index;
   logic [rqs_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/ready_queue_scheduler.sv]
// Top level of the ready queue scheduler: request staging, slot chain and counters.
// The request channel carries one word per scheduler event: enqueue a task with its
// priority, dequeue the next task, or a timer tick. Each request word produces exactly
// one response word holding the chosen task, the idle, yield and overflow flags and
// the queue occupancy after the event.
// A request is captured in an input register and executed once the response register
// is free or being emptied; the slot chain updates all sixteen slots at once on that
// execution, and the response register is loaded in the same cycle. The input register
// holds one request, so a new request is taken only after the previous one has executed.
// The register port takes policy_mode (index 0) and slice_length (index 1) at any
// time and is always ready; writes should be made while no request is in flight.
// If the receiver stalls, the response is held and at most one further request is
// captured and waits in the input register; the request channel then stalls too.
// Reset empties the queue, clears the slice count, selects first-in first-out order
// and sets the slice length to four.
module ready_queue_scheduler (
   input logic       clock,
   input logic       reset,
   rqs_req_if.sink   req_chan,
   rqs_rsp_if.source rsp_chan,
   rqs_csr_if.sink   csr_chan
);

   localparam int DEPTH   = rqs_pkg::QUEUE_DEPTH;
   localparam int COUNT_W = rqs_pkg::COUNT_W;

   logic                          policy_mode_ff;
   logic [rqs_pkg::SLICE_W-1:0]   slice_length_ff;
   logic [rqs_pkg::SLICE_W-1:0]   slice_count_ff, slice_count_in;
   logic [COUNT_W-1:0]            count_ff, count_in;

   logic                          item_valid_ff;
   logic [rqs_pkg::OPCODE_W-1:0]  item_opcode_ff;
   logic [rqs_pkg::ID_W-1:0]      item_id_ff;
   logic [rqs_pkg::PRIO_W-1:0]    item_prio_ff;

   logic                          rsp_valid_ff;
   logic [rqs_pkg::ID_W-1:0]      chosen_id_ff, chosen_id_in;
   logic                          run_idle_ff, run_idle_in;
   logic                          yield_ff, yield_in;
   logic                          overflow_ff, overflow_in;
   logic [rqs_pkg::OCC_W-1:0]     occupancy_ff;

   logic                          execute;
   logic                          queue_full;
   logic                          queue_empty;
   logic [rqs_pkg::PRIO_W-1:0]    sat_prio;
   logic [rqs_pkg::SLICE_W-1:0]   slice_bumped;
   rqs_pkg::cell_ctrl_type        ctrl;

   logic [DEPTH-1:0]              found;
   logic [rqs_pkg::ID_W-1:0]      slot_id   [DEPTH];
   logic [rqs_pkg::PRIO_W-1:0]    slot_prio [DEPTH];

   assign req_chan.ready = !item_valid_ff;
   assign csr_chan.ready = 1'b1;
   assign execute        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign queue_full     = (count_ff == COUNT_W'(DEPTH));
   assign queue_empty    = (count_ff == '0);
   assign sat_prio       = (item_prio_ff > rqs_pkg::PRIO_MAX) ? rqs_pkg::PRIO_MAX : item_prio_ff;
   assign slice_bumped   = (slice_count_ff < rqs_pkg::SLICE_MAX) ?
                           slice_count_ff + 1'b1 : slice_count_ff;

   assign ctrl.enqueue       = execute && (item_opcode_ff == rqs_pkg::OP_ENQUEUE) && !queue_full;
   assign ctrl.dequeue       = execute && (item_opcode_ff == rqs_pkg::OP_DEQUEUE) && !queue_empty;
   assign ctrl.priority_mode = policy_mode_ff;
   assign ctrl.new_id        = item_id_ff;
   assign ctrl.new_prio      = sat_prio;

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      localparam logic [COUNT_W-1:0] SLOT_INDEX = COUNT_W'(i);
      logic                       left_found;
      logic [rqs_pkg::ID_W-1:0]   left_id, right_id;
      logic [rqs_pkg::PRIO_W-1:0] left_prio, right_prio;

      if (i == 0) begin : g_head
         assign left_found = 1'b0;
         assign left_id    = item_id_ff;
         assign left_prio  = sat_prio;
      end else begin : g_body
         assign left_found = found[i-1];
         assign left_id    = slot_id[i-1];
         assign left_prio  = slot_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_id   = slot_id[i];
         assign right_prio = slot_prio[i];
      end else begin : g_inner
         assign right_id   = slot_id[i+1];
         assign right_prio = slot_prio[i+1];
      end

      rqs_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (count_ff > SLOT_INDEX),
         .found_left (left_found),
         .left_id    (left_id),
         .left_prio  (left_prio),
         .right_id   (right_id),
         .right_prio (right_prio),
         .found      (found[i]),
         .id         (slot_id[i]),
         .prio       (slot_prio[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      slice_count_in = slice_count_ff;
      chosen_id_in   = '0;
      run_idle_in    = 1'b0;
      yield_in       = 1'b0;
      overflow_in    = 1'b0;
      case (item_opcode_ff)
         rqs_pkg::OP_ENQUEUE: begin
            if (queue_full) begin
               overflow_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         rqs_pkg::OP_DEQUEUE: begin
            if (queue_empty) begin
               run_idle_in = 1'b1;
            end else begin
               chosen_id_in = slot_id[0];
               count_in     = count_ff - 1'b1;
            end
            slice_count_in = '0;
         end
         rqs_pkg::OP_TICK: begin
            slice_count_in = slice_bumped;
            yield_in       = (slice_bumped >= slice_length_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_mode_ff  <= 1'b0;
         slice_length_ff <= rqs_pkg::SLICE_RESET;
         slice_count_ff  <= '0;
         count_ff        <= '0;
         item_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               rqs_pkg::CSR_POLICY_MODE:  policy_mode_ff  <= csr_chan.data[0];
               rqs_pkg::CSR_SLICE_LENGTH: slice_length_ff <= csr_chan.data;
               default: begin
               end
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            item_valid_ff <= 1'b1;
         end else if (execute) begin
            item_valid_ff <= 1'b0;
         end
         if (execute) begin
            rsp_valid_ff   <= 1'b1;
            count_ff       <= count_in;
            slice_count_ff <= slice_count_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_opcode_ff <= req_chan.opcode;
         item_id_ff     <= req_chan.task_id;
         item_prio_ff   <= req_chan.task_priority;
      end
      if (execute) begin
         chosen_id_ff <= chosen_id_in;
         run_idle_ff  <= run_idle_in;
         yield_ff     <= yield_in;
         overflow_ff  <= overflow_in;
         occupancy_ff <= rqs_pkg::OCC_W'(count_in);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.chosen_id      = chosen_id_ff;
   assign rsp_chan.run_idle       = run_idle_ff;
   assign rsp_chan.yield_request  = yield_ff;
   assign rsp_chan.overflow_error = overflow_ff;
   assign rsp_chan.occupancy      = occupancy_ff;

endmodule

[hdl/rqs_cell.sv]
// One queue slot: holds a task id and priority and shifts with its neighbours.
module rqs_cell (
   input  logic                          clock,
   input  rqs_pkg::cell_ctrl_type        ctrl,
   input  logic                          occupied,
   input  logic                          found_left,
   input  logic [rqs_pkg::ID_W-1:0]      left_id,
   input  logic [rqs_pkg::PRIO_W-1:0]    left_prio,
   input  logic [rqs_pkg::ID_W-1:0]      right_id,
   input  logic [rqs_pkg::PRIO_W-1:0]    right_prio,
   output logic                          found,
   output logic [rqs_pkg::ID_W-1:0]      id,
   output logic [rqs_pkg::PRIO_W-1:0]    prio
);

   logic [rqs_pkg::ID_W-1:0]   id_ff, id_in;
   logic [rqs_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic                       newcomer_higher;

   assign newcomer_higher = ctrl.priority_mode && (ctrl.new_prio > prio_ff);
   assign found = found_left || !occupied || newcomer_higher;

   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      if (ctrl.enqueue) begin
         if (found_left) begin
            id_in   = left_id;
            prio_in = left_prio;
         end else if (found) begin
            id_in   = ctrl.new_id;
            prio_in = ctrl.new_prio;
         end
      end else if (ctrl.dequeue) begin
         id_in   = right_id;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign id   = id_ff;
   assign prio = prio_ff;

endmodule

[test/tb_ready_queue_scheduler.sv]
// Self-checking testbench for the ready queue scheduler: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_ready_queue_scheduler;

   localparam logic [rqs_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int MAX_GAP      = 12;
   localparam int DRAIN_CYCLES = 10;

   typedef enum int {MIX_BALANCED, MIX_FILL, MIX_TICKS} mix_kind_type;

   typedef struct packed {
      logic [rqs_pkg::ID_W-1:0]  chosen_id;
      logic                      run_idle;
      logic                      yield_request;
      logic                      overflow_error;
      logic [rqs_pkg::OCC_W-1:0] occupancy;
   } sched_outcome_type;

   typedef struct {
      logic [rqs_pkg::OPCODE_W-1:0] op;
      logic [rqs_pkg::ID_W-1:0]     id;
      logic [rqs_pkg::PRIO_W-1:0]   prio;
      bit                           pinned;
      sched_outcome_type            want;
   } plan_row_type;

   typedef struct {
      logic                        policy;
      logic [rqs_pkg::SLICE_W-1:0] slice;
      int                          items;
      mix_kind_type                mix;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rqs_req_if req_bus ();
   rqs_rsp_if rsp_bus ();
   rqs_csr_if csr_bus ();

   ready_queue_scheduler u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   logic [rqs_pkg::ID_W-1:0]    queued_ids [rqs_pkg::QUEUE_DEPTH];
   logic [rqs_pkg::PRIO_W-1:0]  queued_prios [rqs_pkg::QUEUE_DEPTH];
   int                          queued_count   = 0;
   logic [rqs_pkg::SLICE_W-1:0] ticks_in_slice = '0;
   logic                        priority_order = 1'b0;
   logic [rqs_pkg::SLICE_W-1:0] slice_limit    = rqs_pkg::SLICE_RESET;

   sched_outcome_type pending_outcomes [$];
   plan_row_type      inflight_rows [$];
   plan_row_type      directed_plan [$];
   phase_type         phases [$];

   int failures       = 0;
   int responses_seen = 0;
   int overflows_seen = 0;
   int idles_seen     = 0;
   int yields_seen    = 0;
   int settings_used  = 0;
   bit req_calm       = 1'b0;
   bit rsp_calm       = 1'b1;
   int rsp_stall      = 0;

   function automatic sched_outcome_type outcome(logic [rqs_pkg::ID_W-1:0] chosen, logic idle,
                                                 logic yield, logic ovf,
                                                 logic [rqs_pkg::OCC_W-1:0] occ);
      sched_outcome_type r;
      r.chosen_id      = chosen;
      r.run_idle       = idle;
      r.yield_request  = yield;
      r.overflow_error = ovf;
      r.occupancy      = occ;
      return r;
   endfunction

   function automatic sched_outcome_type schedule_event(logic [rqs_pkg::OPCODE_W-1:0] op,
                                                        logic [rqs_pkg::ID_W-1:0] id,
                                                        logic [rqs_pkg::PRIO_W-1:0] prio);
      sched_outcome_type r;
      int                pos;
      bit                found;
      r = '0;
      found = 1'b0;
      case (op)
         rqs_pkg::OP_ENQUEUE: begin
            if (queued_count >= rqs_pkg::QUEUE_DEPTH) begin
               r.overflow_error = 1'b1;
            end else begin
               pos = queued_count;
               if (priority_order) begin
                  for (int k = 0; k < queued_count; k++) begin
                     if (!found && prio > queued_prios[k]) begin
                        pos = k;
                        found = 1'b1;
                     end
                  end
               end
               for (int k = queued_count; k > pos; k--) begin
                  queued_ids[k]   = queued_ids[k-1];
                  queued_prios[k] = queued_prios[k-1];
               end
               queued_ids[pos]   = id;
               queued_prios[pos] = prio;
               queued_count++;
            end
         end
         rqs_pkg::OP_DEQUEUE: begin
            if (queued_count == 0) begin
               r.run_idle = 1'b1;
            end else begin
               r.chosen_id = queued_ids[0];
               for (int k = 1; k < queued_count; k++) begin
                  queued_ids[k-1]   = queued_ids[k];
                  queued_prios[k-1] = queued_prios[k];
               end
               queued_count--;
            end
            ticks_in_slice = '0;
         end
         rqs_pkg::OP_TICK: begin
            if (ticks_in_slice != rqs_pkg::SLICE_MAX) ticks_in_slice++;
            if (ticks_in_slice >= slice_limit) r.yield_request = 1'b1;
         end
         default: begin
         end
      endcase
      r.occupancy = rqs_pkg::OCC_W'(queued_count);
      return r;
   endfunction

   function automatic int idle_gap(inout bit calm);
      if ($urandom_range(0, 59) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   task automatic compare_field(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t tb: mismatch in %s: expected %0d, actual %0d", $time, label, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (rqs_pkg::csr_index_type'(csr_bus.index))
               rqs_pkg::CSR_POLICY_MODE:  priority_order = csr_bus.data[0];
               rqs_pkg::CSR_SLICE_LENGTH: slice_limit = csr_bus.data;
               default: begin
               end
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (inflight_rows.size() == 0) begin
               $display("%0t tb: request word accepted that was never driven", $time);
               failures++;
            end else begin
               if (inflight_rows[0].pinned) begin
                  void'(schedule_event(req_bus.opcode, req_bus.task_id, req_bus.task_priority));
                  pending_outcomes.push_back(inflight_rows[0].want);
               end else begin
                  pending_outcomes.push_back(schedule_event(req_bus.opcode, req_bus.task_id,
                                                            req_bus.task_priority));
               end
               void'(inflight_rows.pop_front());
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t tb: unexpected response word: expected none, actual id %0d occ %0d",
                        $time, rsp_bus.chosen_id, rsp_bus.occupancy);
               failures++;
            end else begin
               compare_field("chosen_id", pending_outcomes[0].chosen_id, rsp_bus.chosen_id);
               compare_field("run_idle", 8'(pending_outcomes[0].run_idle),
                             8'(rsp_bus.run_idle));
               compare_field("yield_request", 8'(pending_outcomes[0].yield_request),
                             8'(rsp_bus.yield_request));
               compare_field("overflow_error", 8'(pending_outcomes[0].overflow_error),
                             8'(rsp_bus.overflow_error));
               compare_field("occupancy", 8'(pending_outcomes[0].occupancy),
                             8'(rsp_bus.occupancy));
               overflows_seen += int'(pending_outcomes[0].overflow_error);
               idles_seen     += int'(pending_outcomes[0].run_idle);
               yields_seen    += int'(pending_outcomes[0].yield_request);
               responses_seen++;
               void'(pending_outcomes.pop_front());
            end
            rsp_stall = idle_gap(rsp_calm);
            if (rsp_stall > 0) rsp_bus.ready <= 1'b0;
         end else if (!rsp_bus.ready) begin
            if (rsp_stall <= 1) rsp_bus.ready <= 1'b1;
            rsp_stall--;
         end
      end
   end

   task automatic send_request(input plan_row_type row);
      int gap;
      gap = idle_gap(req_calm);
      inflight_rows.push_back(row);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= row.op;
      req_bus.task_id       <= row.id;
      req_bus.task_priority <= row.prio;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic configure(input logic policy, input logic [rqs_pkg::SLICE_W-1:0] slice);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= rqs_pkg::CSR_POLICY_MODE;
      csr_bus.data  <= rqs_pkg::CSR_DATA_W'(policy);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= rqs_pkg::CSR_SLICE_LENGTH;
      csr_bus.data  <= slice;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic add_row(input logic [rqs_pkg::OPCODE_W-1:0] op,
                          input logic [rqs_pkg::ID_W-1:0] id,
                          input logic [rqs_pkg::PRIO_W-1:0] prio, input bit pinned,
                          input sched_outcome_type want);
      plan_row_type row;
      row.op     = op;
      row.id     = id;
      row.prio   = prio;
      row.pinned = pinned;
      row.want   = want;
      directed_plan.push_back(row);
   endtask

   task automatic add_phase(input logic policy, input logic [rqs_pkg::SLICE_W-1:0] slice,
                            input int items, input mix_kind_type mix);
      phase_type p;
      p.policy = policy;
      p.slice  = slice;
      p.items  = items;
      p.mix    = mix;
      phases.push_back(p);
   endtask

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      plan_row_type row;
      int           pick;

      req_bus.valid         = 1'b0;
      req_bus.opcode        = rqs_pkg::OP_ENQUEUE;
      req_bus.task_id       = '0;
      req_bus.task_priority = '0;
      rsp_bus.ready         = 1'b1;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = rqs_pkg::CSR_POLICY_MODE;
      csr_bus.data          = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_row(rqs_pkg::OP_DEQUEUE, 8'h5A, 6'h15, 1'b1, outcome(8'd0, 1'b1, 1'b0, 1'b0, 5'd0));
      add_row(OP_UNUSED, 8'hFF, 6'h3F, 1'b1, outcome(8'd0, 1'b0, 1'b0, 1'b0, 5'd0));
      add_row(rqs_pkg::OP_TICK, 8'h00, 6'h00, 1'b1, outcome(8'd0, 1'b0, 1'b0, 1'b0, 5'd0));
      add_row(rqs_pkg::OP_TICK, 8'hAA, 6'h2A, 1'b1, outcome(8'd0, 1'b0, 1'b0, 1'b0, 5'd0));
      add_row(rqs_pkg::OP_TICK, 8'h55, 6'h15, 1'b1, outcome(8'd0, 1'b0, 1'b0, 1'b0, 5'd0));
      add_row(rqs_pkg::OP_TICK, 8'hFF, 6'h3F, 1'b1, outcome(8'd0, 1'b0, 1'b1, 1'b0, 5'd0));
      add_row(rqs_pkg::OP_ENQUEUE, 8'hFF, 6'h3F, 1'b1, outcome(8'd0, 1'b0, 1'b0, 1'b0, 5'd1));
      add_row(rqs_pkg::OP_ENQUEUE, 8'h00, 6'h00, 1'b1, outcome(8'd0, 1'b0, 1'b0, 1'b0, 5'd2));
      for (int k = 0; k < rqs_pkg::QUEUE_DEPTH - 2; k++) begin
         add_row(rqs_pkg::OP_ENQUEUE, rqs_pkg::ID_W'(8'h11 * k + 3),
                 rqs_pkg::PRIO_W'(k * 9), 1'b0, '0);
      end
      add_row(rqs_pkg::OP_ENQUEUE, 8'hA5, 6'h2A, 1'b1, outcome(8'd0, 1'b0, 1'b0, 1'b1, 5'd16));
      add_row(rqs_pkg::OP_DEQUEUE, 8'h00, 6'h00, 1'b1, outcome(8'hFF, 1'b0, 1'b0, 1'b0, 5'd15));
      add_row(rqs_pkg::OP_DEQUEUE, 8'h00, 6'h00, 1'b1, outcome(8'h00, 1'b0, 1'b0, 1'b0, 5'd14));

      foreach (directed_plan[i]) send_request(directed_plan[i]);
      settle();

      add_phase(1'b1, 8'd1, 110, MIX_BALANCED);
      add_phase(1'b0, 8'd255, 300, MIX_TICKS);
      add_phase(1'b1, 8'd0, 110, MIX_BALANCED);
      add_phase(1'b1, 8'd255, 120, MIX_FILL);
      add_phase(1'b0, 8'd200, 110, MIX_BALANCED);
      add_phase(1'b1, 8'd3, 100, MIX_FILL);
      add_phase(1'b0, 8'd1, 100, MIX_BALANCED);

      foreach (phases[p]) begin
         configure(phases[p].policy, phases[p].slice);
         repeat (phases[p].items) begin
            pick = $urandom_range(0, 99);
            case (phases[p].mix)
               MIX_BALANCED: row.op = (pick < 45) ? rqs_pkg::OP_ENQUEUE :
                                      (pick < 80) ? rqs_pkg::OP_DEQUEUE :
                                      (pick < 97) ? rqs_pkg::OP_TICK : OP_UNUSED;
               MIX_FILL:     row.op = (pick < 70) ? rqs_pkg::OP_ENQUEUE :
                                      (pick < 85) ? rqs_pkg::OP_DEQUEUE :
                                      (pick < 97) ? rqs_pkg::OP_TICK : OP_UNUSED;
               default:      row.op = (pick < 4) ? rqs_pkg::OP_ENQUEUE :
                                      (pick < 99) ? rqs_pkg::OP_TICK : OP_UNUSED;
            endcase
            row.id     = rqs_pkg::ID_W'($urandom_range(0, 255));
            row.prio   = rqs_pkg::PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                               : $urandom_range(0, 63));
            row.pinned = 1'b0;
            row.want   = '0;
            send_request(row);
         end
         settle();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d response words checked across %0d register settings.",
               responses_seen, settings_used);
      $display("tb: %0d overflows, %0d idle dequeues and %0d yield requests were predicted.",
               overflows_seen, idles_seen, yields_seen);
      if (failures == 0 && pending_outcomes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/rqs_pkg.sv
hdl/rqs_channels.sv
hdl/rqs_cell.sv
hdl/ready_queue_scheduler.sv
test/tb_ready_queue_scheduler.sv
